// ----- design/gnms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared constants and helpers of the gradient non-maximum suppression unit.
// ----------------------------------------------------------------------------
package gnms_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAG_ROWS   = 8;
  localparam int DIR_ROWS   = 4;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MAG_DEPTH  = MAG_ROWS * MAX_WIDTH;
  localparam int DIR_DEPTH  = DIR_ROWS * MAX_WIDTH;
  localparam int MAG_AW     = $clog2(MAG_DEPTH);
  localparam int DIR_AW     = $clog2(DIR_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  // Quantized gradient directions.
  localparam logic [1:0] DIR_0   = 2'd0;
  localparam logic [1:0] DIR_45  = 2'd1;
  localparam logic [1:0] DIR_90  = 2'd2;
  localparam logic [1:0] DIR_135 = 2'd3;

  typedef struct packed {
    logic signed [2:0] drow;
    logic signed [2:0] dcol;
  } tap_ofs_t;

  // Offset of neighbor tap j (0 far-before, 1 near-before, 2 near-after, 3 far-after).
  function automatic tap_ofs_t tap_offset(input logic [1:0] dir, input logic [1:0] j);
    tap_ofs_t o;
    logic signed [2:0] step;
    case (j)
      2'd0:    step = -3'sd2;
      2'd1:    step = -3'sd1;
      2'd2:    step = 3'sd1;
      default: step = 3'sd2;
    endcase
    case (dir)
      DIR_0: begin
        o.drow = 3'sd0;
        o.dcol = step;
      end
      DIR_45: begin
        o.drow = step;
        o.dcol = step;
      end
      DIR_90: begin
        o.drow = step;
        o.dcol = 3'sd0;
      end
      default: begin
        o.drow = step;
        o.dcol = -step;
      end
    endcase
    return o;
  endfunction

endpackage

// ----- design/gnms_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/gradient_nonmax_suppression_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_nonmax_suppression_unit
// Canny thinning stage: gradient magnitude and direction per pixel, kept
// only where the pixel is the first maximum of five taps along its direction.
// ----------------------------------------------------------------------------
// Input items carry grad_x and grad_y in raster order (tuser low) or a flush
// tick (tuser high). Each gradient pixel is written into line stores held in
// two RAMs. Once 2*W+3 pixels are pending, the pixel two rows and two columns
// back is judged and one result item leaves with tlast on the frame's last
// pixel. After the last pixel of a frame, flush ticks drain the rest, one
// result each; the next pixel starts a new frame.
// The magnitude comes from a bit-serial square root. The emit sequence is
// bound by the single read port of the magnitude RAM: the direction and
// five taps are read one after another.
// Results sit in an output register, so a stalled receiver only holds the
// block when the next result is ready. Reset returns to 640x480 and an empty
// frame; RAM contents need no clearing since every read hits a pixel written
// earlier in the same frame. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
module gradient_nonmax_suppression_unit import gnms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // grad_x [10:0], grad_y [21:11], zero [23:22]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // thin_magnitude [7:0]
  output logic        out_tlast,  // end_of_frame
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ROOT, S_RND, S_WR, S_DIR, S_DIRW, S_TAP, S_TAPW, S_OUT
  } state_t;

  state_t state_r;
  logic [10:0] fw_r;
  logic [12:0] fh_r;
  logic [COL_W-1:0] col_r, ocol_r;
  logic [12:0] row_r;
  logic [11:0] orow_r;
  logic [11:0] pend_r;
  logic signed [10:0] gx_r, gy_r;
  logic [21:0] n_r;
  logic [22:0] hi2_r;
  logic [25:0] lo2_r;
  logic [23:0] df2_r;
  logic zero_r, le_r, gxpos_r;
  logic [7:0] s_r, bit_r, mag_r;
  logic [1:0] dirq_r;
  logic [2:0] k_r;
  logic [7:0] center_r;
  logic keep_r;
  logic out_tvalid_r, out_last_r;
  logic [7:0] out_data_r;

  // Effective frame size.
  logic [10:0] eff_w;
  logic [12:0] eff_h;
  always_comb begin
    if (fw_r == 11'd0) eff_w = 11'd1;
    else if (fw_r > 11'(MAX_WIDTH)) eff_w = 11'(MAX_WIDTH);
    else eff_w = fw_r;
    if (fh_r == 13'd0) eff_h = 13'd1;
    else if (fh_r > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
    else eff_h = fh_r;
  end

  // Products for magnitude and direction sector tests.
  logic signed [11:0] sx, sy;
  logic [11:0] ax, ay;
  logic [12:0] lo_sum;
  logic [11:0] df;
  logic signed [21:0] gxx, gyy;
  always_comb begin
    sx = gy_r[10] ? -12'(gx_r) : 12'(gx_r);
    sy = gy_r[10] ? -12'(gy_r) : 12'(gy_r);
    ax = sx[11] ? 12'(-sx) : 12'(sx);
    ay = 12'(sy);
    lo_sum = {1'b0, ay} + {1'b0, ax};
    df = ay - ax;
    gxx = gx_r * gx_r;
    gyy = gy_r * gy_r;
  end

  logic [1:0] dir_q;
  always_comb begin
    if (zero_r) dir_q = DIR_0;
    else if (lo2_r < 26'(hi2_r)) dir_q = DIR_0;
    else if (le_r || (24'(df2_r) < 24'(hi2_r))) dir_q = gxpos_r ? DIR_45 : DIR_135;
    else dir_q = DIR_90;
  end

  // Square root step and rounding.
  logic [7:0] t_try;
  logic [15:0] t_sq;
  logic [16:0] s_sq_s;
  always_comb begin
    t_try = s_r | bit_r;
    t_sq = t_try * t_try;
    s_sq_s = 17'(s_r * s_r) + 17'(s_r);
  end

  // Tap address for the emit sequence.
  tap_ofs_t ofs;
  logic signed [13:0] rr_s;
  logic signed [11:0] cc_s;
  logic [11:0] rr;
  logic [COL_W-1:0] cc;
  always_comb begin
    if (k_r == 3'd0) begin
      ofs.drow = 3'sd0;
      ofs.dcol = 3'sd0;
    end else begin
      ofs = tap_offset(dirq_r, 2'(k_r - 3'd1));
    end
    rr_s = $signed({2'b00, orow_r}) + 14'(ofs.drow);
    cc_s = $signed({2'b00, ocol_r}) + 12'(ofs.dcol);
    if (rr_s < 0) rr = 12'd0;
    else if (rr_s >= $signed({1'b0, eff_h})) rr = 12'(eff_h - 13'd1);
    else rr = 12'(rr_s);
    if (cc_s < 0) cc = '0;
    else if (cc_s >= $signed({1'b0, eff_w})) cc = COL_W'(eff_w - 11'd1);
    else cc = COL_W'(cc_s);
  end

  logic mag_we;
  logic [MAG_AW-1:0] mag_raddr;
  logic [7:0] mag_rd;
  logic [1:0] dir_rd;
  assign mag_we = (state_r == S_WR);
  assign mag_raddr = {rr[$clog2(MAG_ROWS)-1:0], cc};

  gnms_ram #(.WIDTH(8), .DEPTH(MAG_DEPTH)) u_mag_ram (
    .clk     (clk),
    .wr_en   (mag_we),
    .wr_addr ({row_r[$clog2(MAG_ROWS)-1:0], col_r}),
    .wr_data (mag_r),
    .rd_addr (mag_raddr),
    .rd_data (mag_rd)
  );

  gnms_ram #(.WIDTH(2), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk     (clk),
    .wr_en   (mag_we),
    .wr_addr ({row_r[$clog2(DIR_ROWS)-1:0], col_r}),
    .wr_data (dir_q),
    .rd_addr ({orow_r[$clog2(DIR_ROWS)-1:0], ocol_r}),
    .rd_data (dir_rd)
  );

  logic [12:0] pend_inc;
  logic [11:0] emit_lim;
  logic eof;
  assign pend_inc = {1'b0, pend_r} + 13'd1;
  assign emit_lim = {eff_w, 1'b0} + 12'd2;
  assign eof = ({1'b0, orow_r} == eff_h - 13'd1) && ({1'b0, ocol_r} == eff_w - 11'd1);

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fw_r <= 11'd640;
      fh_r <= 13'd480;
      col_r <= '0;
      row_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      pend_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;
      if (cfg_wr_en && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) fw_r <= cfg_data[10:0];
        else fh_r <= cfg_data;
        col_r <= '0;
        row_r <= '0;
        ocol_r <= '0;
        orow_r <= '0;
        pend_r <= '0;
      end else begin
        case (state_r)
          S_IDLE: begin
            if (in_tvalid) begin
              if (in_tuser) begin
                if (row_r >= eff_h && pend_r != 12'd0) state_r <= S_DIR;
              end else begin
                gx_r <= in_tdata[10:0];
                gy_r <= in_tdata[21:11];
                if (row_r >= eff_h) begin
                  col_r <= '0;
                  row_r <= '0;
                  ocol_r <= '0;
                  orow_r <= '0;
                  pend_r <= '0;
                end
                state_r <= S_SQ;
              end
            end
          end
          S_SQ: begin
            n_r <= 22'(gxx) + 22'(gyy);
            hi2_r <= {22'(ax * ax), 1'b0};
            lo2_r <= lo_sum * lo_sum;
            df2_r <= df * df;
            le_r <= (ay <= ax);
            zero_r <= (gx_r == 11'sd0) && (gy_r == 11'sd0);
            gxpos_r <= (sx > 12'sd0);
            s_r <= 8'd0;
            bit_r <= 8'h80;
            state_r <= S_ROOT;
          end
          S_ROOT: begin
            if (22'(t_sq) <= n_r) s_r <= t_try;
            bit_r <= bit_r >> 1;
            if (bit_r[0]) state_r <= S_RND;
          end
          S_RND: begin
            if (n_r >= 22'd65281) mag_r <= 8'd255;
            else if (n_r > 22'(s_sq_s)) mag_r <= s_r + 8'd1;
            else mag_r <= s_r;
            state_r <= S_WR;
          end
          S_WR: begin
            if ({1'b0, col_r} + 11'd1 >= eff_w) begin
              col_r <= '0;
              row_r <= row_r + 13'd1;
            end else begin
              col_r <= col_r + COL_W'(1);
            end
            pend_r <= 12'(pend_inc);
            state_r <= (pend_inc > {1'b0, emit_lim}) ? S_DIR : S_IDLE;
          end
          S_DIR: state_r <= S_DIRW;
          S_DIRW: begin
            dirq_r <= dir_rd;
            k_r <= 3'd0;
            keep_r <= 1'b1;
            state_r <= S_TAP;
          end
          S_TAP: state_r <= S_TAPW;
          S_TAPW: begin
            // Earlier taps win ties, so they suppress on equality.
            if (k_r == 3'd0) center_r <= mag_rd;
            else if (k_r <= 3'd2 ? mag_rd >= center_r : mag_rd > center_r) keep_r <= 1'b0;
            if (k_r == 3'd4) begin
              state_r <= S_OUT;
            end else begin
              k_r <= k_r + 3'd1;
              state_r <= S_TAP;
            end
          end
          S_OUT: begin
            if (!out_tvalid_r || out_tready) begin
              out_tvalid_r <= 1'b1;
              out_data_r <= keep_r ? center_r : 8'd0;
              out_last_r <= eof;
              if ({1'b0, ocol_r} + 11'd1 >= eff_w) begin
                ocol_r <= '0;
                orow_r <= orow_r + 12'd1;
              end else begin
                ocol_r <= ocol_r + COL_W'(1);
              end
              pend_r <= pend_r - 12'd1;
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  // A new result only appears from the output step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_OUT))
    else $error("result without emit step");

  // Between items the pending count never exceeds the emit threshold.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ({1'b0, pend_r} <= {1'b0, emit_lim}))
    else $error("pending count above threshold");

  // An emit never starts with nothing pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIR) |-> (pend_r != 12'd0))
    else $error("emit with empty pipeline");

endmodule

// ----- tb/gnms_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_checker
// Watches the gradient, result and register ports of the suppression unit,
// models the line stores and the five-tap test itself, and compares every
// result item field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module gnms_checker import gnms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // grad_x [10:0], grad_y [21:11], zero [23:22]
  input  logic        in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // thin_magnitude [7:0]
  input  logic        out_tlast,  // end_of_frame
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          mismatch_count,
  output int          awaited_count,
  output int          checked_count
);

  typedef struct packed {
    logic [7:0] magnitude;
    logic       frame_end;
  } thin_result_t;

  thin_result_t thin_q[$];
  logic [7:0]   mag_store [MAG_ROWS * MAX_WIDTH];
  logic [1:0]   dir_store [DIR_ROWS * MAX_WIDTH];
  int unsigned  width_reg, height_reg;
  int unsigned  in_col, in_row, pixels_waiting, judge_col, judge_row;

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    checked_count  = 0;
  end

  function automatic int unsigned active_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic logic [7:0] rounded_root(int unsigned n);
    int unsigned s, t;
    s = 0;
    if (n >= 65281) return 8'd255;
    for (int unsigned b = 128; b != 0; b >>= 1) begin
      t = s + b;
      if (t * t <= n) s = t;
    end
    if (n > s * s + s) s++;
    return s[7:0];
  endfunction

  // Sector tests use squared terms, so tan(22.5) and tan(67.5) are exact.
  function automatic logic [1:0] gradient_sector(int gx, int gy);
    int unsigned ax, ay, sum, twice_sq;
    if (gy < 0) begin
      gx = -gx;
      gy = -gy;
    end
    if (gx == 0 && gy == 0) return DIR_0;
    ax = (gx < 0) ? -gx : gx;
    ay = gy;
    twice_sq = 2 * ax * ax;
    sum = ay + ax;
    if (sum * sum < twice_sq) return DIR_0;
    if (ay <= ax || (ay - ax) * (ay - ax) < twice_sq) return (gx > 0) ? DIR_45 : DIR_135;
    return DIR_90;
  endfunction

  function automatic int unsigned edge_clip(int v, int unsigned lim);
    if (v < 0) return 0;
    if (v >= int'(lim)) return lim - 1;
    return v;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    pixels_waiting = 0;
    judge_col = 0;
    judge_row = 0;
  endfunction

  // Judges the oldest waiting pixel against its four neighbors.
  function automatic void judge_pixel();
    int unsigned  w, h, r, c, center, rr, cc, v;
    int           step, dr, dc;
    logic [1:0]   dir;
    bit           keep;
    thin_result_t res;
    w = active_width();
    h = active_height();
    r = judge_row;
    c = judge_col % MAX_WIDTH;
    dir = dir_store[(r % DIR_ROWS) * MAX_WIDTH + c];
    center = mag_store[(r % MAG_ROWS) * MAX_WIDTH + c];
    keep = 1;
    for (int k = 0; k < 4; k++) begin
      step = (k < 2) ? k - 2 : k - 1;
      dr = (dir == DIR_0) ? 0 : step;
      dc = (dir == DIR_90) ? 0 : ((dir == DIR_135) ? -step : step);
      rr = edge_clip(int'(r) + dr, h);
      cc = edge_clip(int'(c) + dc, w);
      v = mag_store[(rr % MAG_ROWS) * MAX_WIDTH + cc];
      // Earlier taps win ties.
      if (k < 2 ? v >= center : v > center) keep = 0;
    end
    res.magnitude = keep ? center[7:0] : 8'd0;
    res.frame_end = (r == h - 1 && c == w - 1);
    thin_q.push_back(res);
    judge_col++;
    if (judge_col >= w) begin
      judge_col = 0;
      judge_row++;
    end
    pixels_waiting--;
  endfunction

  function automatic void take_item(logic op, logic [23:0] data);
    int unsigned w, h, c;
    int          gx, gy;
    w = active_width();
    h = active_height();
    if (op) begin
      if (in_row >= h && pixels_waiting > 0) judge_pixel();
      return;
    end
    if (in_row >= h) restart_frame();
    gx = $signed(data[10:0]);
    gy = $signed(data[21:11]);
    c = in_col % MAX_WIDTH;
    mag_store[(in_row % MAG_ROWS) * MAX_WIDTH + c] = rounded_root(gx * gx + gy * gy);
    dir_store[(in_row % DIR_ROWS) * MAX_WIDTH + c] = gradient_sector(gx, gy);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    pixels_waiting++;
    if (pixels_waiting > 2 * w + 2) judge_pixel();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    thin_result_t want;
    if (!rst_n) begin
      width_reg = 640;
      height_reg = 480;
      restart_frame();
      thin_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (thin_q.size() == 0) begin
          report_mismatch("unexpected result item", out_tdata, -1);
        end else begin
          want = thin_q.pop_front();
          if (out_tdata !== want.magnitude) report_mismatch("thin_magnitude", out_tdata,
                                                            want.magnitude);
          if (out_tlast !== want.frame_end) report_mismatch("end_of_frame", out_tlast,
                                                            want.frame_end);
          checked_count++;
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data[10:0];
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
        end
      end
      if (in_tvalid && in_tready) take_item(in_tuser, in_tdata);
    end
    awaited_count = thin_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the gradient non-maximum suppression unit: directed
// corner pixels, extreme frame sizes, then random frames under three
// backpressure mixes, with all checking done in gnms_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import gnms_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [23:0] in_tdata;   // grad_x [10:0], grad_y [21:11], zero [23:22]
  logic        out_tvalid, out_tready, out_tlast;
  logic [7:0]  out_tdata;  // thin_magnitude [7:0]
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  int mismatch_count, awaited_count, checked_count;
  int tx_idle, rx_idle;
  int items_sent, reg_writes, cycle_count;
  int unsigned cur_width;

  gradient_nonmax_suppression_unit dut (.*);

  gnms_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** gradient_nonmax_suppression_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_item(logic op, int gx, int gy);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, 11'(gy), 11'(gx)};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_pixel(int gx, int gy);
    send_item(1'b0, gx, gy);
  endtask

  // Flush ticks carry random junk that the block must ignore.
  task automatic send_flush();
    send_item(1'b1, $urandom_range(2040) - 1020, $urandom_range(2040) - 1020);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[12:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    if (idx == REG_FRAME_WIDTH) begin
      cur_width = value[10:0];
      if (cur_width < 1) cur_width = 1;
      if (cur_width > MAX_WIDTH) cur_width = MAX_WIDTH;
    end
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic drain(int extra);
    repeat (2 * cur_width + 2 + extra) send_flush();
  endtask

  function automatic int pick_gradient();
    case ($urandom_range(3))
      0:       return $urandom_range(2040) - 1020;
      1:       return $urandom_range(12) - 6;
      2:       return $urandom_range(120) - 60;
      default: return ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) != 0) ? 1020 : -1020);
    endcase
  endfunction

  task automatic random_frames(int quota);
    int stop_at, w, h, pixels, shape;
    bit keep_size;
    stop_at = items_sent + quota;
    keep_size = 0;
    while (items_sent < stop_at) begin
      if (!keep_size) begin
        w = ($urandom_range(9) < 8) ? $urandom_range(8, 1) : $urandom_range(12);
        h = $urandom_range(6);
        if ($urandom_range(7) == 0)
          write_reg(2'($urandom_range(3, 2)), $urandom_range(8191));
        set_frame(w, h);
      end
      keep_size = 0;
      pixels = cur_width * ((h < 1) ? 1 : h);
      shape = $urandom_range(9);
      if (shape == 0) pixels = $urandom_range(pixels);
      for (int i = 0; i < pixels; i++) begin
        if ($urandom_range(19) == 0) send_flush();
        send_pixel(pick_gradient(), pick_gradient());
      end
      if (shape == 1) begin
        // Partial drain, then the next frame begins straight away.
        repeat ($urandom_range(2 * cur_width + 2)) send_flush();
        keep_size = 1;
      end else if (shape != 0) begin
        drain($urandom_range(2));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    out_tready = 1'b0;
    cur_width = 640;
    tx_idle = 7;
    rx_idle = 54;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Corner pixels on a 3x3 frame: saturation, all sectors, zero gradient,
    // sector boundaries, early flush and flush with nothing pending.
    set_frame(3, 3);
    send_flush();
    send_pixel(0, 0);
    send_pixel(1020, 1020);
    send_pixel(-1020, -1020);
    send_pixel(1020, -1020);
    send_pixel(0, 1020);
    send_pixel(-1020, 0);
    send_flush();
    send_pixel(12, 5);
    send_pixel(5, 12);
    send_pixel(-5, 12);
    drain(2);
    send_pixel(7, -3);
    send_pixel(0, -1020);

    // Size registers at and beyond their limits.
    set_frame(0, 0);
    send_pixel(100, 100);
    drain(1);
    set_frame(2047, 8191);
    repeat (20) send_pixel(pick_gradient(), pick_gradient());
    send_flush();
    set_frame(1024, 1);
    repeat (60) send_pixel(pick_gradient(), pick_gradient());
    send_flush();
    set_frame(1, 4096);
    repeat (40) send_pixel(pick_gradient(), pick_gradient());
    send_flush();

    random_frames(380);
    tx_idle = 54;
    rx_idle = 7;
    random_frames(380);
    tx_idle = 0;
    rx_idle = 0;
    random_frames(380);

    wait_idle();
    $display("Sent %0d items through %0d register writes; %0d results checked.",
             items_sent, reg_writes, checked_count);
    $display("Covered corner gradients, size extremes, early flushes and restarts.");
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("** gradient_nonmax_suppression_unit: PASSED **");
    end else begin
      $display("** gradient_nonmax_suppression_unit: FAILED **");
    end
    $finish;
  end

endmodule
